FILE: sv/vet_pkg.sv
`timescale 1ns / 1ps
package vet_pkg;

	localparam int ENTRIES     = 64;
	localparam int MAX_MATCHES = 16;
	localparam int IDX_W       = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int NW          = $clog2(MAX_MATCHES + 1);
	localparam int BUF_W       = (MAX_MATCHES > 1) ? $clog2(MAX_MATCHES) : 1;
	// a pass lets the wave cross every cell and settle after a table write
	localparam int PASS_LEN    = ENTRIES + 1;
	localparam int TMR_W       = $clog2(PASS_LEN + 1);

	typedef enum logic [2:0] {
		OP_ADD, OP_ADD_VER, OP_REMOVE, OP_LOOKUP,
		OP_QUERY_FWD, OP_QUERY_REV, OP_ERASE, OP_CLEAR
	} op_t;

	typedef enum logic [2:0] {
		ST_OK, ST_INVALID, ST_STALE, ST_NOT_FOUND, ST_FULL
	} status_t;

	typedef struct packed {
		op_t         op;
		logic [63:0] type_id;
		logic [31:0] from_entity;
		logic [31:0] to_entity;
		logic [63:0] value;
		logic [31:0] version;
		logic [4:0]  max_out;
	} req_t;

	typedef struct packed {
		status_t     status;
		logic [31:0] entity;
		logic [63:0] edge_value;
		logic [31:0] edge_version;
		logic [4:0]  count;
		logic        last;
	} rsp_t;

	// key, write data and commands broadcast to every cell
	typedef struct packed {
		logic [63:0]      typ;
		logic [31:0]      src;
		logic [31:0]      tgt;
		logic [63:0]      val;
		logic [31:0]      stamp;
		logic             fwd;
		logic             have_prev;
		logic [31:0]      prev;
		logic [IDX_W-1:0] idx;
		logic             wr_en;
		logic             rm_en;
		logic             erase_en;
		logic             clear_en;
	} bcast_t;

	// running selection handed from cell to cell
	typedef struct packed {
		logic             hit_f;
		logic [IDX_W-1:0] hit_idx;
		logic [63:0]      hit_pay;
		logic [31:0]      hit_stamp;
		logic             free_f;
		logic [IDX_W-1:0] free_idx;
		logic             min_f;
		logic [31:0]      min_other;
		logic [63:0]      min_pay;
	} cand_t;

endpackage

FILE: sv/vet_if.sv
`timescale 1ns / 1ps
interface vet_req_if;
	import vet_pkg::*;
	logic valid;
	logic ready;
	req_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface vet_rsp_if;
	import vet_pkg::*;
	logic valid;
	logic ready;
	rsp_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

FILE: sv/versioned_edge_table.sv
`timescale 1ns / 1ps
// Adds, removes and lookups take one scan of the cell chain, then one output beat.
// Queries take one scan per match found (plus one closing scan if fewer than the limit),
// then one beat per match, each loaded and then held until taken; erase, clear, rejected adds and
// zero-limit queries answer in the cycle after they are taken, without a scan.
// Throughput: one item at a time; a new item is taken only after the last beat of the previous one.
// Reset: arst_n clears every valid bit, the revision and invalid_entity at once.
module versioned_edge_table import vet_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata,
	vet_req_if.sink     req,
	vet_rsp_if.source   rsp
);

	// Broadcast key and commands from the controller to every cell.
	bcast_t bc;

	// Candidate wave: cell i hands its running best, registered, to cell i+1,
	// so once the wave has crossed every cell the tail of the chain holds the verdict of the
	// whole table: first hit on the key, first free slot, smallest endpoint
	// above the previous one emitted.
	cand_t  chain [ENTRIES+1];

	assign chain[0] = '0;

	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		vet_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.idx      (IDX_W'(i)),
			.bc       (bc),
			.cand_in  (chain[i]),
			.cand_out (chain[i+1])
		);
	end

	// Controller: hold the item, wait out the wave, commit the write, removal,
	// erase or clear, and drive the output beats from a registered stage.
	vet_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req),
		.rsp       (rsp),
		.res       (chain[ENTRIES]),
		.bc        (bc)
	);

endmodule

FILE: sv/vet_cell.sv
`timescale 1ns / 1ps
module vet_cell import vet_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [IDX_W-1:0] idx,
	input  bcast_t           bc,
	input  cand_t            cand_in,
	output cand_t            cand_out
);

	logic        valid_q;
	logic [63:0] typ_q;
	logic [31:0] src_q;
	logic [31:0] tgt_q;
	logic [63:0] pay_q;
	logic [31:0] stamp_q;

	logic        hit, cand, sel_mine;
	logic [31:0] key, other;
	cand_t       nxt;

	always_comb begin
		key   = bc.fwd ? src_q : tgt_q;
		other = bc.fwd ? tgt_q : src_q;
		hit   = valid_q && typ_q == bc.typ && src_q == bc.src && tgt_q == bc.tgt;
		cand  = valid_q && typ_q == bc.typ && key == (bc.fwd ? bc.src : bc.tgt) &&
			(!bc.have_prev || other > bc.prev);
		sel_mine = cand && (!cand_in.min_f || other < cand_in.min_other);
		nxt = cand_in;
		// keep the earliest hit and free slot, the smallest other endpoint
		if (!cand_in.hit_f && hit) begin
			nxt.hit_f     = 1'b1;
			nxt.hit_idx   = idx;
			nxt.hit_pay   = pay_q;
			nxt.hit_stamp = stamp_q;
		end
		if (!cand_in.free_f && !valid_q) begin
			nxt.free_f   = 1'b1;
			nxt.free_idx = idx;
		end
		if (sel_mine) begin
			nxt.min_f     = 1'b1;
			nxt.min_other = other;
			nxt.min_pay   = pay_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (bc.clear_en) begin
			valid_q <= 1'b0;
		end else if (bc.erase_en && (src_q == bc.src || tgt_q == bc.src)) begin
			valid_q <= 1'b0;
		end else if (bc.rm_en && idx == bc.idx) begin
			valid_q <= 1'b0;
		end else if (bc.wr_en && idx == bc.idx) begin
			valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (bc.wr_en && idx == bc.idx) begin
			typ_q   <= bc.typ;
			src_q   <= bc.src;
			tgt_q   <= bc.tgt;
			pay_q   <= bc.val;
			stamp_q <= bc.stamp;
		end
		cand_out <= nxt;
	end

endmodule

FILE: sv/vet_ctrl.sv
`timescale 1ns / 1ps
module vet_ctrl import vet_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata,
	vet_req_if.sink     req,
	vet_rsp_if.source   rsp,
	input  cand_t       res,
	output bcast_t      bc
);

	typedef enum logic [1:0] {S_IDLE, S_PASS, S_RESULT, S_LIST} state_t;

	state_t            state_q;
	logic [31:0]       inv_q;
	logic [31:0]       rev_q;
	op_t               op_q;
	logic [63:0]       typ_q;
	logic [31:0]       f_q;
	logic [31:0]       to_q;
	logic [63:0]       val_q;
	logic [31:0]       ver_q;
	logic [31:0]       stamp_q;
	logic [NW-1:0]     limit_q;
	logic [NW-1:0]     n_q;
	logic [BUF_W-1:0]  emit_q;
	logic [31:0]       prev_q;
	logic              have_prev_q;
	logic [TMR_W-1:0]  tmr_q;
	logic [IDX_W-1:0]  idx_q;
	logic              wr_q, rm_q, erase_q, clear_q;
	logic              out_valid_q;
	rsp_t              out_q;
	logic [31:0]       buf_other_q [MAX_MATCHES];
	logic [63:0]       buf_pay_q   [MAX_MATCHES];

	logic              stale, ver_local;
	logic [31:0]       stamp_new;
	logic [NW-1:0]     lim;
	logic              pass_end, add_ok, key_bad, take;

	assign req.ready = (state_q == S_IDLE);
	assign rsp.valid = out_valid_q;
	assign rsp.data  = out_q;

	always_comb begin
		bc.typ       = typ_q;
		bc.src       = f_q;
		bc.tgt       = to_q;
		bc.val       = val_q;
		bc.stamp     = stamp_q;
		bc.fwd       = (op_q == OP_QUERY_FWD);
		bc.have_prev = have_prev_q;
		bc.prev      = prev_q;
		bc.idx       = idx_q;
		bc.wr_en     = wr_q;
		bc.rm_en     = rm_q;
		bc.erase_en  = erase_q;
		bc.clear_en  = clear_q;
	end

	always_comb begin
		ver_local = !(op_q == OP_ADD_VER && ver_q != 32'd0);
		stale     = res.hit_f && !ver_local && ver_q <= res.hit_stamp;
		stamp_new = ver_local ? rev_q + 32'd1 : ver_q;
		if (7'(req.data.max_out) > 7'(MAX_MATCHES))
			lim = NW'(MAX_MATCHES);
		else
			lim = NW'(req.data.max_out);
		pass_end = (state_q == S_PASS) && (tmr_q == TMR_W'(PASS_LEN - 1));
		add_ok   = !stale && (res.hit_f || res.free_f);
		take     = (state_q == S_IDLE) && req.valid;
		key_bad  = (req.data.op == OP_ADD || req.data.op == OP_ADD_VER) &&
			(req.data.type_id == 64'd0 || req.data.from_entity == inv_q ||
			req.data.to_entity == inv_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			inv_q       <= '0;
			rev_q       <= '0;
			out_valid_q <= 1'b0;
			wr_q        <= 1'b0;
			rm_q        <= 1'b0;
			erase_q     <= 1'b0;
			clear_q     <= 1'b0;
			have_prev_q <= 1'b0;
			tmr_q       <= '0;
			n_q         <= '0;
			emit_q      <= '0;
		end else begin
			// one-cycle strobes to the cells
			wr_q    <= pass_end && (op_q == OP_ADD || op_q == OP_ADD_VER) && add_ok;
			rm_q    <= pass_end && op_q == OP_REMOVE && res.hit_f;
			erase_q <= take && req.data.op == OP_ERASE;
			clear_q <= take && req.data.op == OP_CLEAR;
			if (cfg_we)
				inv_q <= cfg_wdata;
			case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						op_q        <= req.data.op;
						typ_q       <= req.data.type_id;
						f_q         <= req.data.from_entity;
						to_q        <= req.data.to_entity;
						val_q       <= req.data.value;
						ver_q       <= req.data.version;
						limit_q     <= lim;
						n_q         <= '0;
						have_prev_q <= 1'b0;
						tmr_q       <= '0;
						out_q       <= '{status: (key_bad ? ST_INVALID : ST_OK),
							last: 1'b1, default: '0};
						case (req.data.op)
							OP_ADD, OP_ADD_VER: begin
								if (key_bad) begin
									out_valid_q <= 1'b1;
									state_q     <= S_RESULT;
								end else begin
									state_q <= S_PASS;
								end
							end
							OP_REMOVE, OP_LOOKUP: state_q <= S_PASS;
							OP_QUERY_FWD, OP_QUERY_REV: begin
								if (lim == '0) begin
									out_valid_q <= 1'b1;
									state_q     <= S_RESULT;
								end else begin
									state_q <= S_PASS;
								end
							end
							OP_ERASE: begin
								out_valid_q <= 1'b1;
								state_q     <= S_RESULT;
							end
							default: begin
								rev_q       <= '0;
								out_valid_q <= 1'b1;
								state_q     <= S_RESULT;
							end
						endcase
					end
				end
				S_PASS: begin
					if (!pass_end) begin
						tmr_q <= tmr_q + TMR_W'(1);
					end else begin
						tmr_q <= '0;
						case (op_q)
							OP_ADD, OP_ADD_VER: begin
								out_valid_q <= 1'b1;
								state_q     <= S_RESULT;
								if (stale) begin
									out_q.status <= ST_STALE;
								end else if (!res.hit_f && !res.free_f) begin
									out_q.status <= ST_FULL;
								end else begin
									idx_q              <= res.hit_f ? res.hit_idx : res.free_idx;
									stamp_q            <= stamp_new;
									out_q.edge_version <= stamp_new;
									if (ver_local)
										rev_q <= rev_q + 32'd1;
								end
							end
							OP_REMOVE, OP_LOOKUP: begin
								out_valid_q <= 1'b1;
								state_q     <= S_RESULT;
								if (!res.hit_f) begin
									out_q.status <= ST_NOT_FOUND;
								end else if (op_q == OP_REMOVE) begin
									idx_q <= res.hit_idx;
									rev_q <= rev_q + 32'd1;
								end else begin
									out_q.edge_value   <= res.hit_pay;
									out_q.edge_version <= res.hit_stamp;
								end
							end
							default: begin
								if (res.min_f) begin
									buf_other_q[n_q[BUF_W-1:0]] <= res.min_other;
									buf_pay_q[n_q[BUF_W-1:0]]   <= res.min_pay;
									n_q         <= n_q + NW'(1);
									prev_q      <= res.min_other;
									have_prev_q <= 1'b1;
									if (n_q + NW'(1) == limit_q) begin
										emit_q  <= '0;
										state_q <= S_LIST;
									end
								end else if (n_q == '0) begin
									out_q.status <= ST_NOT_FOUND;
									out_valid_q  <= 1'b1;
									state_q      <= S_RESULT;
								end else begin
									emit_q  <= '0;
									state_q <= S_LIST;
								end
							end
						endcase
					end
				end
				S_RESULT: begin
					if (rsp.ready) begin
						out_valid_q <= 1'b0;
						state_q     <= S_IDLE;
					end
				end
				S_LIST: begin
					if (!out_valid_q) begin
						out_q.status       <= ST_OK;
						out_q.entity       <= buf_other_q[emit_q];
						out_q.edge_value   <= buf_pay_q[emit_q];
						out_q.edge_version <= '0;
						out_q.count        <= 5'(n_q);
						out_q.last         <= (NW'(emit_q) + NW'(1) == n_q);
						out_valid_q        <= 1'b1;
					end else if (rsp.ready) begin
						out_valid_q <= 1'b0;
						if (out_q.last)
							state_q <= S_IDLE;
						else
							emit_q <= emit_q + BUF_W'(1);
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

FILE: sv/vet_checker.sv
`timescale 1ns / 1ps
module vet_checker import vet_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input logic rsp_valid,
	input logic rsp_ready,
	input rsp_t rsp_data
);

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("result beat dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> $stable(rsp_data))
		else $error("result beat changed while stalled");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("second item taken while one is in flight");

	a_free: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_ready && rsp_data.last |=> req_ready)
		else $error("not ready after final beat");

	a_err_single: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.status != ST_OK |-> rsp_data.last && rsp_data.count == 5'd0)
		else $error("error result not a single beat");

endmodule

bind versioned_edge_table vet_checker u_vet_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_data  (rsp.data)
);
